/* design/lrws_pkg.sv */
`default_nettype none

package lrws_pkg;

  typedef enum logic [1:0] {
    OP_RESTART  = 2'd0,
    OP_WRITE    = 2'd1,
    OP_UNIFORM  = 2'd2,
    OP_WEIGHTED = 2'd3
  } op_e;

  localparam int unsigned GEN_W   = 31;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned SLOT_W  = 8;
  localparam int unsigned WIN_W   = 16;
  localparam int unsigned CNT_W   = 9;
  localparam int unsigned DRAWN_W = 9;
  localparam int unsigned IN_W    = 40;
  localparam int unsigned OUT_W   = 48;

  localparam int unsigned CHUNK_W = 16;
  localparam int unsigned MUL_W   = GEN_W + CHUNK_W;

  localparam logic [CHUNK_W-1:0] LEHMER_MULT = 16'd16807;
  localparam logic [GEN_W:0]     LEHMER_MOD  = 32'h7FFF_FFFF;

  localparam int unsigned CFG_AW = 3;
  localparam logic        REG_START_SEED = 1'b0;
  localparam logic [GEN_W-1:0] SEED_RESET = 31'd1;

endpackage

`default_nettype wire

/* design/lrws_ram.sv */
`default_nettype none

module lrws_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* design/lehmer_rng_weighted_sampler.sv */
// Minimal-standard multiplicative generator (s <- 16807*s mod 2^31-1) with a weight
// store of MAX_ITEMS entries of WEIGHT_BITS bits. One beat in, one beat out per
// item; s_axis_tready is low while an item is in work, and a finished result waits
// in the output register so the next item may enter meanwhile. In a weighted
// draw, n = min(count, MAX_ITEMS), C = ceil((WEIGHT_BITS + log2(MAX_ITEMS)) / 16):
// the single read port of the weight store walks n weights once to sum them and
// once more to find the index, and the shared 31x16 multiplier forms seed times
// total in C passes. A stalled output register holds a finished result in the
// finish step. The weight store powers up undefined; draw only over slots already
// written.
`default_nettype none

module lehmer_rng_weighted_sampler #(
  parameter int unsigned MAX_ITEMS   = 256,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // operation[1:0], slot[9:2], weight[25:10], count[34:26]
  input  wire logic [lrws_pkg::IN_W-1:0]       s_axis_tdata,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // drawn[8:0], sample[39:9], fault[40]
  output logic [lrws_pkg::OUT_W-1:0]           m_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [lrws_pkg::CFG_AW-1:0]     paddr,
  input  wire logic [31:0]                     pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  localparam int unsigned GW   = lrws_pkg::GEN_W;
  localparam int unsigned CKW  = lrws_pkg::CHUNK_W;
  localparam int unsigned MW   = lrws_pkg::MUL_W;
  localparam int unsigned AW   = $clog2(MAX_ITEMS);
  localparam int unsigned CW   = $clog2(MAX_ITEMS + 1);
  localparam int unsigned NW   = (CW > lrws_pkg::CNT_W) ? CW : lrws_pkg::CNT_W;
  localparam int unsigned SW   = WEIGHT_BITS + AW;
  localparam int unsigned NCH  = (SW + CKW - 1) / CKW;
  localparam int unsigned TPW  = NCH * CKW;
  localparam int unsigned PRW  = TPW + GW;
  localparam int unsigned KW   = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int unsigned WKEEP = (WEIGHT_BITS < lrws_pkg::WIN_W) ? WEIGHT_BITS
                                                                  : lrws_pkg::WIN_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADV_MUL,
    ST_ADV_RED,
    ST_U_MUL,
    ST_U_DIV,
    ST_SUM,
    ST_T_MUL,
    ST_T_ACC,
    ST_SCAN,
    ST_FIN
  } state_e;

  state_e                        state_q;
  lrws_pkg::op_e                 op_q;
  logic [lrws_pkg::CNT_W-1:0]    count_q;
  logic [CW-1:0]                 n_q;
  logic [GW-1:0]                 seed_q;
  logic [GW-1:0]                 s_q;
  logic [MW-1:0]                 mul_q;
  logic [CW-1:0]                 rd_cnt_q;
  logic                          rv_q;
  logic [AW-1:0]                 rd_idx_q;
  logic [SW-1:0]                 tot_q;
  logic [TPW-1:0]                tsh_q;
  logic [KW-1:0]                 kcnt_q;
  logic [PRW-1:0]                prod_q;
  logic [SW-1:0]                 acc_q;
  logic                          a1v_q;
  logic [AW-1:0]                 a1i_q;
  logic [PRW-1:0]                accm_q;
  logic                          a2v_q;
  logic [AW-1:0]                 a2i_q;
  logic [lrws_pkg::DRAWN_W-1:0]  res_drawn_q;
  logic                          res_fault_q;
  logic                          m_valid_q;
  logic [lrws_pkg::OUT_W-1:0]    m_data_q;

  lrws_pkg::op_e                 in_op;
  logic [lrws_pkg::SLOT_W-1:0]   in_slot;
  logic [lrws_pkg::WIN_W-1:0]    in_weight;
  logic [lrws_pkg::CNT_W-1:0]    in_count;
  logic                          in_fire;
  logic                          cfg_wr;
  logic [NW-1:0]                 cnt_ext;
  logic [NW-1:0]                 n_sat;
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [WEIGHT_BITS-1:0]        ram_wdata;
  logic [AW-1:0]                 ram_raddr;
  logic [WEIGHT_BITS-1:0]        ram_rdata;
  logic [CKW-1:0]                mul_b;
  logic [MW-1:0]                 mul_res;
  logic [GW:0]                   red_sum;
  logic [GW:0]                   red_val;
  logic [CKW-1:0]                u_hi;
  logic [lrws_pkg::CNT_W:0]      u_q;
  logic [lrws_pkg::CNT_W:0]      u_draw;
  logic                          issue;
  logic [CW-1:0]                 n_m1;
  logic [AW-1:0]                 last_idx;
  logic                          hit;

  assign in_op     = lrws_pkg::op_e'(s_axis_tdata[1:0]);
  assign in_slot   = s_axis_tdata[9:2];
  assign in_weight = s_axis_tdata[25:10];
  assign in_count  = s_axis_tdata[34:26];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[lrws_pkg::CFG_AW-1] == lrws_pkg::REG_START_SEED);
  assign prdata = (paddr[lrws_pkg::CFG_AW-1] == lrws_pkg::REG_START_SEED)
                  ? {1'b0, seed_q} : 32'd0;

  assign cnt_ext = NW'(in_count);
  assign n_sat   = (cnt_ext > NW'(MAX_ITEMS)) ? NW'(MAX_ITEMS) : cnt_ext;

  assign ram_we    = in_fire && (in_op == lrws_pkg::OP_WRITE)
                     && (32'(in_slot) < 32'(MAX_ITEMS));
  assign ram_waddr = AW'(in_slot);
  assign ram_wdata = WEIGHT_BITS'(in_weight[WKEEP-1:0]);
  assign ram_raddr = rd_cnt_q[AW-1:0];

  lrws_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    case (state_q)
      ST_ADV_MUL: mul_b = lrws_pkg::LEHMER_MULT;
      ST_U_MUL:   mul_b = CKW'(count_q);
      ST_T_MUL:   mul_b = tsh_q[TPW-1 -: CKW];
      default:    mul_b = '0;
    endcase
  end

  assign mul_res = MW'(s_q) * MW'(mul_b);

  assign red_sum = {1'b0, mul_q[GW-1:0]} + (GW+1)'(mul_q[MW-1:GW]);
  assign red_val = (red_sum >= lrws_pkg::LEHMER_MOD) ? red_sum - lrws_pkg::LEHMER_MOD
                                                      : red_sum;

  assign u_hi   = mul_q[MW-1:GW];
  assign u_q    = (lrws_pkg::CNT_W+1)'(u_hi)
                  + (lrws_pkg::CNT_W+1)'(red_sum >= lrws_pkg::LEHMER_MOD);
  assign u_draw = (u_q + 1'b1 > {1'b0, count_q}) ? {1'b0, count_q} : u_q + 1'b1;

  assign issue    = ((state_q == ST_SUM) || (state_q == ST_SCAN)) && (rd_cnt_q != n_q);
  assign n_m1     = n_q - CW'(1);
  assign last_idx = n_m1[AW-1:0];
  assign hit      = a2v_q && ((accm_q >= prod_q) || (a2i_q == last_idx));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= lrws_pkg::OP_RESTART;
      count_q     <= '0;
      n_q         <= '0;
      seed_q      <= lrws_pkg::SEED_RESET;
      s_q         <= lrws_pkg::SEED_RESET;
      mul_q       <= '0;
      rd_cnt_q    <= '0;
      rv_q        <= 1'b0;
      rd_idx_q    <= '0;
      tot_q       <= '0;
      tsh_q       <= '0;
      kcnt_q      <= '0;
      prod_q      <= '0;
      acc_q       <= '0;
      a1v_q       <= 1'b0;
      a1i_q       <= '0;
      accm_q      <= '0;
      a2v_q       <= 1'b0;
      a2i_q       <= '0;
      res_drawn_q <= '0;
      res_fault_q <= 1'b0;
      m_valid_q   <= 1'b0;
      m_data_q    <= '0;
    end else begin
      mul_q <= mul_res;
      if (cfg_wr) begin
        seed_q <= pwdata[GW-1:0];
      end
      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      rv_q     <= issue;
      rd_idx_q <= rd_cnt_q[AW-1:0];
      if (issue) begin
        rd_cnt_q <= rd_cnt_q + CW'(1);
      end

      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            op_q        <= in_op;
            count_q     <= in_count;
            n_q         <= CW'(n_sat);
            res_drawn_q <= '0;
            res_fault_q <= 1'b0;
            if (in_op == lrws_pkg::OP_RESTART) begin
              s_q     <= seed_q;
              state_q <= ST_FIN;
            end else if (in_op == lrws_pkg::OP_WRITE) begin
              state_q <= ST_FIN;
            end else begin
              state_q <= ST_ADV_MUL;
            end
          end
        end
        ST_ADV_MUL: begin
          state_q <= ST_ADV_RED;
        end
        ST_ADV_RED: begin
          s_q      <= red_val[GW-1:0];
          rd_cnt_q <= '0;
          tot_q    <= '0;
          if (count_q == '0) begin
            res_fault_q <= 1'b1;
            state_q     <= ST_FIN;
          end else if (op_q == lrws_pkg::OP_UNIFORM) begin
            state_q <= ST_U_MUL;
          end else begin
            state_q <= ST_SUM;
          end
        end
        ST_U_MUL: begin
          state_q <= ST_U_DIV;
        end
        ST_U_DIV: begin
          res_drawn_q <= u_draw[lrws_pkg::DRAWN_W-1:0];
          state_q     <= ST_FIN;
        end
        ST_SUM: begin
          if (rv_q) begin
            tot_q <= tot_q + SW'(ram_rdata);
          end else if (rd_cnt_q == n_q) begin
            tsh_q   <= TPW'(tot_q);
            kcnt_q  <= KW'(NCH - 1);
            prod_q  <= '0;
            state_q <= ST_T_MUL;
          end
        end
        ST_T_MUL: begin
          state_q <= ST_T_ACC;
        end
        ST_T_ACC: begin
          prod_q <= (prod_q << CKW) + PRW'(mul_q);
          tsh_q  <= tsh_q << CKW;
          if (kcnt_q == '0) begin
            rd_cnt_q <= '0;
            acc_q    <= '0;
            a1v_q    <= 1'b0;
            a2v_q    <= 1'b0;
            state_q  <= ST_SCAN;
          end else begin
            kcnt_q  <= kcnt_q - KW'(1);
            state_q <= ST_T_MUL;
          end
        end
        ST_SCAN: begin
          if (rv_q) begin
            acc_q <= acc_q + SW'(ram_rdata);
          end
          a1v_q  <= rv_q;
          a1i_q  <= rd_idx_q;
          accm_q <= (PRW'(acc_q) << GW) - PRW'(acc_q);
          a2v_q  <= a1v_q;
          a2i_q  <= a1i_q;
          if (hit) begin
            res_drawn_q <= lrws_pkg::DRAWN_W'(a2i_q);
            a1v_q       <= 1'b0;
            a2v_q       <= 1'b0;
            rd_cnt_q    <= n_q;
            state_q     <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!m_valid_q || m_axis_tready) begin
            m_data_q  <= lrws_pkg::OUT_W'({res_fault_q, s_q, res_drawn_q});
            m_valid_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_walk_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM || state_q == ST_SCAN) |-> (n_q != '0))
    else $error("weight walk entered with empty range");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM || state_q == ST_SCAN) |-> (rd_cnt_q <= n_q))
    else $error("weight read counter ran past range");

  a_state_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(state_q == ST_ADV_RED) |-> ((GW+1)'(s_q) < lrws_pkg::LEHMER_MOD))
    else $error("generator state not reduced below modulus");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> ($past(state_q) == ST_FIN && state_q == ST_IDLE))
    else $error("result beat raised outside finish step");

endmodule

`default_nettype wire
